// ===== hw/rtl/wmd_pkg.sv =====
// ============================================================================
// wmd_pkg - shared types and constants for the word multiply/divide unit
// Operation codes, field widths, iteration counts and the command/status
// structs that join the controller and the datapath.
// ============================================================================
package wmd_pkg;

  // Field widths
  localparam int unsigned WORD_W = 16;
  localparam int unsigned LONG_W = 32;

  // Iterations of the shared shift/add-subtract unit
  localparam int unsigned MUL_STEPS  = WORD_W;
  localparam int unsigned DIV_STEPS  = LONG_W;
  localparam int unsigned STEP_CNT_W = $clog2(DIV_STEPS);

  // Quotient range limits (magnitudes)
  localparam logic [LONG_W-1:0] QUO_POS_MAX = 32'h0000_7FFF;
  localparam logic [LONG_W-1:0] QUO_NEG_MAX = 32'h0000_8000;

  // Operation codes
  typedef enum logic [1:0] {
    CMD_MULU = 2'd0,
    CMD_MULS = 2'd1,
    CMD_DIVU = 2'd2,
    CMD_DIVS = 2'd3
  } wmd_cmd_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // take a new word into the working registers
    logic step;      // one iteration of multiply or divide
    logic load_out;  // capture the fixed-up result into the output register
  } wmd_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic is_mul;    // operation in flight is a multiply
  } wmd_stat_t;

endpackage

// ===== hw/rtl/wmd_in_if.sv =====
// ============================================================================
// wmd_in_if - operand channel
// Valid/ready channel carrying the operation and both operands.
// ============================================================================
interface wmd_in_if;
  import wmd_pkg::*;

  logic                valid;
  logic                ready;
  wmd_cmd_t            cmd;
  logic [LONG_W-1:0]   dest_value;
  logic [WORD_W-1:0]   source_word;

  modport source (output valid, output cmd, output dest_value, output source_word,
                  input ready);
  modport sink   (input valid, input cmd, input dest_value, input source_word,
                  output ready);
endinterface

// ===== hw/rtl/wmd_out_if.sv =====
// ============================================================================
// wmd_out_if - result channel
// Valid/ready channel carrying the result word and the flag updates.
// ============================================================================
interface wmd_out_if;
  import wmd_pkg::*;

  logic              valid;
  logic              ready;
  logic [LONG_W-1:0] result_value;
  logic              write_back;
  logic              status;
  logic              nz_update;
  logic              flag_n;
  logic              flag_z;
  logic              vc_update;
  logic              flag_v;
  logic              flag_c;

  modport source (output valid, output result_value, output write_back, output status,
                  output nz_update, output flag_n, output flag_z, output vc_update,
                  output flag_v, output flag_c, input ready);
  modport sink   (input valid, input result_value, input write_back, input status,
                  input nz_update, input flag_n, input flag_z, input vc_update,
                  input flag_v, input flag_c, output ready);
endinterface

// ===== hw/rtl/wmd_datapath.sv =====
// ============================================================================
// wmd_datapath - operand registers, shared iteration unit and result register
// Works on magnitudes: a shift-add multiplier (one bit a step) and a
// restoring divider (one quotient bit a step), then fixes signs, checks
// quotient range and forms the flags.
// ============================================================================
module wmd_datapath (
  input  logic                        clk,
  input  wmd_pkg::wmd_cmd_t           cmd,
  input  logic [wmd_pkg::LONG_W-1:0]  dest_value,
  input  logic [wmd_pkg::WORD_W-1:0]  source_word,
  input  wmd_pkg::wmd_ctl_t           ctl,
  output wmd_pkg::wmd_stat_t          stat,
  output logic [wmd_pkg::LONG_W-1:0]  result_value,
  output logic                        write_back,
  output logic                        status,
  output logic                        nz_update,
  output logic                        flag_n,
  output logic                        flag_z,
  output logic                        vc_update,
  output logic                        flag_v,
  output logic                        flag_c
);
  import wmd_pkg::*;

  // Working registers
  wmd_cmd_t            cmd_r;
  logic                a_neg;    // dividend or multiplicand negative
  logic                b_neg;    // divisor or multiplier negative
  logic                div_zero;
  logic [WORD_W-1:0]   opa;      // multiplicand or divisor magnitude
  logic [WORD_W-1:0]   rem;      // partial remainder or product high half
  logic [LONG_W-1:0]   quo;      // dividend/quotient, or multiplier/product low half

  // Operand decode at load
  logic                in_signed;
  logic                in_mul;
  logic                in_a_neg;
  logic                in_b_neg;
  logic [WORD_W-1:0]   src_mag;
  logic [WORD_W-1:0]   dlo_mag;
  logic [LONG_W-1:0]   d_mag;

  assign in_signed = (cmd == CMD_MULS) || (cmd == CMD_DIVS);
  assign in_mul    = (cmd == CMD_MULU) || (cmd == CMD_MULS);
  assign in_a_neg  = in_signed && (in_mul ? dest_value[WORD_W-1] : dest_value[LONG_W-1]);
  assign in_b_neg  = in_signed && source_word[WORD_W-1];
  assign src_mag   = in_b_neg ? (WORD_W'(0) - source_word) : source_word;
  assign dlo_mag   = in_a_neg ? (WORD_W'(0) - dest_value[WORD_W-1:0])
                              : dest_value[WORD_W-1:0];
  assign d_mag     = in_a_neg ? (LONG_W'(0) - dest_value) : dest_value;

  // One iteration of the shared unit
  logic                is_mul;
  logic [WORD_W:0]     mul_sum;
  logic [WORD_W:0]     div_sh;
  logic                div_ge;
  logic [WORD_W:0]     div_diff;

  assign is_mul   = (cmd_r == CMD_MULU) || (cmd_r == CMD_MULS);
  assign mul_sum  = {1'b0, rem} + (quo[0] ? {1'b0, opa} : {(WORD_W+1){1'b0}});
  assign div_sh   = {rem, quo[LONG_W-1]};
  assign div_ge   = div_sh >= {1'b0, opa};
  assign div_diff = div_sh - {1'b0, opa};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r    <= cmd;
      a_neg    <= in_a_neg;
      b_neg    <= in_b_neg;
      div_zero <= (source_word == '0);
      rem      <= '0;
      if (in_mul) begin
        opa <= dlo_mag;
        quo <= {{(LONG_W-WORD_W){1'b0}}, src_mag};
      end else begin
        opa <= src_mag;
        quo <= d_mag;
      end
    end else if (ctl.step) begin
      if (is_mul) begin
        rem               <= mul_sum[WORD_W:1];
        quo[WORD_W-1:0]   <= {mul_sum[0], quo[WORD_W-1:1]};
      end else begin
        rem <= div_ge ? div_diff[WORD_W-1:0] : div_sh[WORD_W-1:0];
        quo <= {quo[LONG_W-2:0], div_ge};
      end
    end
  end

  assign stat.is_mul = is_mul;

  // Sign fix-up, range check and flags
  logic                res_neg;
  logic [LONG_W-1:0]   p_mag;
  logic [LONG_W-1:0]   prod;
  logic [WORD_W-1:0]   q_word;
  logic [WORD_W-1:0]   r_word;
  logic                q_ovf;

  logic [LONG_W-1:0]   nx_value;
  logic                nx_wb;
  logic                nx_status;
  logic                nx_nzu;
  logic                nx_n;
  logic                nx_z;
  logic                nx_vcu;
  logic                nx_v;

  assign res_neg = a_neg ^ b_neg;
  assign p_mag   = {rem, quo[WORD_W-1:0]};
  assign prod    = res_neg ? (LONG_W'(0) - p_mag) : p_mag;
  assign q_word  = res_neg ? (WORD_W'(0) - quo[WORD_W-1:0]) : quo[WORD_W-1:0];
  assign r_word  = a_neg ? (WORD_W'(0) - rem) : rem;

  always_comb begin
    q_ovf = 1'b0;
    case (cmd_r)
      CMD_DIVU: q_ovf = (quo[LONG_W-1:WORD_W] != '0);
      CMD_DIVS: q_ovf = res_neg ? (quo > QUO_NEG_MAX) : (quo > QUO_POS_MAX);
      default:  q_ovf = 1'b0;
    endcase
  end

  always_comb begin
    nx_value  = '0;
    nx_wb     = 1'b0;
    nx_status = 1'b0;
    nx_nzu    = 1'b0;
    nx_n      = 1'b0;
    nx_z      = 1'b0;
    nx_vcu    = 1'b0;
    nx_v      = 1'b0;
    if (is_mul) begin
      nx_value = prod;
      nx_wb    = 1'b1;
      nx_nzu   = 1'b1;
      nx_n     = prod[LONG_W-1];
      nx_z     = (prod == '0);
      nx_vcu   = 1'b1;
    end else if (div_zero) begin
      nx_status = 1'b1;
    end else if (q_ovf) begin
      nx_vcu = 1'b1;
      nx_v   = 1'b1;
    end else begin
      nx_value = {r_word, q_word};
      nx_wb    = 1'b1;
      nx_nzu   = 1'b1;
      nx_n     = q_word[WORD_W-1];
      nx_z     = (q_word == '0);
      nx_vcu   = 1'b1;
    end
  end

  // Output register: holds the word until the sink takes it
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      result_value <= nx_value;
      write_back   <= nx_wb;
      status       <= nx_status;
      nz_update    <= nx_nzu;
      flag_n       <= nx_n;
      flag_z       <= nx_z;
      vc_update    <= nx_vcu;
      flag_v       <= nx_v;
      flag_c       <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/wmd_controller.sv =====
// ============================================================================
// wmd_controller - sequencing for the word multiply/divide unit
// Takes a word when idle, runs 16 or 32 iterations, then hands the result
// to the output register once that register is free.
// ============================================================================
module wmd_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  wmd_pkg::wmd_stat_t  stat,
  output wmd_pkg::wmd_ctl_t   ctl
);
  import wmd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  state_t                 state;
  logic [STEP_CNT_W-1:0]  cnt;
  logic                   last_step;
  logic                   out_free;

  function automatic logic is_last(input logic [STEP_CNT_W-1:0] c, input logic mul);
    is_last = mul ? (c == STEP_CNT_W'(MUL_STEPS - 1)) : (c == STEP_CNT_W'(DIV_STEPS - 1));
  endfunction

  assign last_step = is_last(cnt, stat.is_mul);
  assign out_free  = !out_valid || out_ready;

  // Commands to the datapath
  assign in_ready     = (state == ST_IDLE);
  assign ctl.load     = in_valid && in_ready;
  assign ctl.step     = (state == ST_RUN);
  assign ctl.load_out = (state == ST_FINISH) && out_free;

  // State, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // new result in, or the waiting one taken
      if (ctl.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (in_valid) state <= ST_RUN;
        end
        ST_RUN: begin
          cnt <= cnt + 1'b1;
          if (last_step) state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/word_multiply_divide_unit_top.sv =====
// ============================================================================
// word_multiply_divide_unit_top - 16x16 multiply and 32/16 divide
// Unsigned and signed word multiply and divide with condition-flag results,
// built as a controller state machine over a one-bit-per-cycle datapath.
// ============================================================================
//
//  channel | dir | handshake     | word
//  --------+-----+---------------+------------------------------------------
//  in      | in  | valid / ready | cmd, dest_value, source_word
//  out     | out | valid / ready | result_value, write_back, status, flags
//
//  Multiply: accept, 16 shift-add steps, then fix-up; divide: accept,
//  32 restoring steps, then fix-up. The step count of the shared
//  shift/add-subtract unit sets how long each operation runs.
//  One word is in flight at a time; a new word is taken while the previous
//  result still waits in the output register.
//  A stalled result holds the fix-up stage until the output register frees.
//  rst is synchronous and clears the controller only.
module word_multiply_divide_unit_top (
  input  logic      clk,
  input  logic      rst,
  wmd_in_if.sink    in,
  wmd_out_if.source out
);
  import wmd_pkg::*;

  wmd_ctl_t  ctl;
  wmd_stat_t stat;

  wmd_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in.valid),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  wmd_datapath u_dp (
    .clk          (clk),
    .cmd          (in.cmd),
    .dest_value   (in.dest_value),
    .source_word  (in.source_word),
    .ctl          (ctl),
    .stat         (stat),
    .result_value (out.result_value),
    .write_back   (out.write_back),
    .status       (out.status),
    .nz_update    (out.nz_update),
    .flag_n       (out.flag_n),
    .flag_z       (out.flag_z),
    .vc_update    (out.vc_update),
    .flag_v       (out.flag_v),
    .flag_c       (out.flag_c)
  );

endmodule

// ===== hw/rtl/wmd_checker.sv =====
// ============================================================================
// wmd_checker - port-level checks for the word multiply/divide unit
// Watches the top level's channels and checks busy behaviour and the
// consistency of the result word's flag fields.
// ============================================================================
module wmd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [wmd_pkg::LONG_W-1:0]  result_value,
  input logic                        write_back,
  input logic                        status,
  input logic                        nz_update,
  input logic                        flag_n,
  input logic                        flag_z,
  input logic                        vc_update,
  input logic                        flag_v,
  input logic                        flag_c
);
  import wmd_pkg::*;

  // Only one word in flight: busy right after a take
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high the cycle after a word was taken");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(write_back)
      && $stable(status) && $stable(flag_v))
    else $error("stalled result changed");

  // Divide by zero reports nothing else
  a_div_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !write_back && !nz_update && !vc_update
      && (result_value == '0))
    else $error("divide-by-zero result carries an update");

  // Overflow: no write, no N/Z update, N and Z left clear
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    out_valid && flag_v |-> vc_update && !write_back && !nz_update && !status
      && !flag_n && !flag_z)
    else $error("overflow result writes or updates N/Z");

  // A write always updates all four flags, clear V and C
  a_write: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_back |-> nz_update && vc_update && !flag_v && !flag_c
      && (flag_n == result_value[WORD_W-1] || flag_n == result_value[LONG_W-1]))
    else $error("written result has inconsistent flags");

endmodule

bind word_multiply_divide_unit_top wmd_checker u_wmd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in.valid),
  .in_ready     (in.ready),
  .out_valid    (out.valid),
  .out_ready    (out.ready),
  .result_value (out.result_value),
  .write_back   (out.write_back),
  .status       (out.status),
  .nz_update    (out.nz_update),
  .flag_n       (out.flag_n),
  .flag_z       (out.flag_z),
  .vc_update    (out.vc_update),
  .flag_v       (out.flag_v),
  .flag_c       (out.flag_c)
);

// ===== dv/word_multiply_divide_unit_top_tb.sv =====
// ============================================================================
// word_multiply_divide_unit_top_tb - self-checking bench for the mul/div unit
// Sends directed corner words, then random multiply and divide words. Most
// divides are built from a chosen quotient and remainder so that they land
// in range or just past it. Every result word is checked field by field
// against a predictor of the unit. Both channels idle in random bursts. The
// result side also holds off once for a long stretch, and the operand side
// twice waits for the unit to drain.
// ============================================================================
`timescale 1ns / 1ps

module word_multiply_divide_unit_top_tb;
  import wmd_pkg::*;

  localparam int unsigned RANDOM_OPS  = 1450;
  localparam int unsigned CALM_TAIL   = 150;    // no idling over the last words
  localparam int unsigned HOLD_AT     = 400;    // result count that starts the long hold
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 60;     // settle time after the last result
  localparam int unsigned CYCLE_LIMIT = 500000;

  // One operand word and the result word it should give
  typedef struct {
    wmd_cmd_t          cmd;
    logic [LONG_W-1:0] dest;
    logic [WORD_W-1:0] src;
    bit                drain;   // wait for every result before sending this one
  } muldiv_op_t;

  typedef struct packed {
    logic [LONG_W-1:0] value;
    logic              wb;
    logic              status;
    logic              nzu;
    logic              n;
    logic              z;
    logic              vcu;
    logic              v;
    logic              c;
  } outcome_t;

  logic clk;
  logic rst;

  wmd_in_if  in_ch ();
  wmd_out_if out_ch ();

  word_multiply_divide_unit_top u_top (
    .clk (clk),
    .rst (rst),
    .in  (in_ch.sink),
    .out (out_ch.source)
  );

  muldiv_op_t  muldiv_ops_q[$];
  outcome_t    expected_outcomes_q[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned send_gap;
  int unsigned take_gap;
  int unsigned hold_left;
  int unsigned cycle_count;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Predictor: expected result word for one operand word
  function automatic outcome_t calc_outcome(muldiv_op_t op);
    outcome_t          o;
    logic [LONG_W-1:0] a;
    logic [LONG_W-1:0] b;
    logic [LONG_W-1:0] quo;
    logic [LONG_W-1:0] rem;
    logic [LONG_W-1:0] dmag;
    logic [LONG_W-1:0] smag;
    logic              dneg;
    logic              qneg;
    o = '0;
    case (op.cmd)
      CMD_MULU, CMD_MULS: begin
        if (op.cmd == CMD_MULU) begin
          a = {16'h0, op.dest[WORD_W-1:0]};
          b = {16'h0, op.src};
        end else begin
          a = {{16{op.dest[WORD_W-1]}}, op.dest[WORD_W-1:0]};
          b = {{16{op.src[WORD_W-1]}}, op.src};
        end
        o.value = a * b;   // low 32 bits agree for both signednesses
        o.wb    = 1'b1;
        o.nzu   = 1'b1;
        o.n     = o.value[LONG_W-1];
        o.z     = (o.value == '0);
        o.vcu   = 1'b1;
      end
      default: begin
        if (op.src == '0) begin
          // divide by zero: trap only, nothing written
          o.status = 1'b1;
          return o;
        end
        if (op.cmd == CMD_DIVU) begin
          quo = op.dest / {16'h0, op.src};
          rem = op.dest % {16'h0, op.src};
          if (quo > 32'h0000_FFFF) begin
            o.vcu = 1'b1;
            o.v   = 1'b1;
            return o;
          end
        end else begin
          dneg = op.dest[LONG_W-1];
          qneg = dneg ^ op.src[WORD_W-1];
          dmag = dneg ? (32'h0 - op.dest) : op.dest;
          smag = op.src[WORD_W-1] ? (32'h0001_0000 - {16'h0, op.src}) : {16'h0, op.src};
          quo  = dmag / smag;
          rem  = dmag % smag;
          // quotient outside -32768..32767, most negative / -1 included
          if (qneg ? (quo > QUO_NEG_MAX) : (quo > QUO_POS_MAX)) begin
            o.vcu = 1'b1;
            o.v   = 1'b1;
            return o;
          end
          if (qneg) quo = 32'h0 - quo;
          if (dneg) rem = 32'h0 - rem;
        end
        o.value = {rem[WORD_W-1:0], quo[WORD_W-1:0]};
        o.wb    = 1'b1;
        o.nzu   = 1'b1;
        o.n     = quo[WORD_W-1];
        o.z     = (quo[WORD_W-1:0] == '0);
        o.vcu   = 1'b1;
      end
    endcase
    return o;
  endfunction

  task automatic queue_op(wmd_cmd_t cmd, logic [LONG_W-1:0] dest, logic [WORD_W-1:0] src,
                          bit drain);
    muldiv_op_t op;
    op.cmd   = cmd;
    op.dest  = dest;
    op.src   = src;
    op.drain = drain;
    muldiv_ops_q.push_back(op);
  endtask

  task automatic report_mismatch(string what, logic [LONG_W-1:0] got, logic [LONG_W-1:0] want);
    mismatches++;
    $display("[%0t] MISMATCH result %0d %s: got 0x%0h, want 0x%0h",
             $realtime, results_seen, what, got, want);
  endtask

  // Operand driver
  always @(posedge clk) begin
    muldiv_op_t op;
    if (rst) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        op.cmd  = in_ch.cmd;
        op.dest = in_ch.dest_value;
        op.src  = in_ch.source_word;
        expected_outcomes_q.push_back(calc_outcome(op));
        if (muldiv_ops_q.size() > CALM_TAIL && $urandom_range(0, 4) == 0)
          send_gap = $urandom_range(1, 9);
      end
      if (in_ch.valid && !in_ch.ready) begin
        // word still on offer: hold it
      end else if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (muldiv_ops_q.size() != 0 &&
                   !(muldiv_ops_q[0].drain && expected_outcomes_q.size() != 0)) begin
        op = muldiv_ops_q.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= op.cmd;
        in_ch.dest_value  <= op.dest;
        in_ch.source_word <= op.src;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      take_gap  = 0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.result_value, out_ch.write_back, out_ch.status, out_ch.nz_update,
               out_ch.flag_n, out_ch.flag_z, out_ch.vc_update, out_ch.flag_v, out_ch.flag_c};
        if (expected_outcomes_q.size() == 0) begin
          report_mismatch("unexpected word", got.value, '0);
        end else begin
          want = expected_outcomes_q.pop_front();
          if (got.value  !== want.value)  report_mismatch("result_value", got.value, want.value);
          if (got.wb     !== want.wb)
            report_mismatch("write_back", LONG_W'(got.wb), LONG_W'(want.wb));
          if (got.status !== want.status)
            report_mismatch("status", LONG_W'(got.status), LONG_W'(want.status));
          if (got.nzu    !== want.nzu)
            report_mismatch("nz_update", LONG_W'(got.nzu), LONG_W'(want.nzu));
          if (got.n      !== want.n)
            report_mismatch("flag_n", LONG_W'(got.n), LONG_W'(want.n));
          if (got.z      !== want.z)
            report_mismatch("flag_z", LONG_W'(got.z), LONG_W'(want.z));
          if (got.vcu    !== want.vcu)
            report_mismatch("vc_update", LONG_W'(got.vcu), LONG_W'(want.vcu));
          if (got.v      !== want.v)
            report_mismatch("flag_v", LONG_W'(got.v), LONG_W'(want.v));
          if (got.c      !== want.c)
            report_mismatch("flag_c", LONG_W'(got.c), LONG_W'(want.c));
        end
        results_seen++;
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      // long hold first, then random stall bursts, none near the end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        out_ch.ready <= 1'b0;
      end else if (muldiv_ops_q.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
        take_gap = $urandom_range(0, 8);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [LONG_W-1:0] dest_corner[8];
    logic [WORD_W-1:0] src_corner[5];
    wmd_cmd_t          cmd;
    logic [LONG_W-1:0] dest;
    logic [WORD_W-1:0] src;
    logic [LONG_W-1:0] quo;
    logic [LONG_W-1:0] smag;
    logic [LONG_W-1:0] dmag;
    logic              dneg;
    logic              qneg;
    int unsigned       qmax;

    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_MULU;
    in_ch.dest_value  = '0;
    in_ch.source_word = '0;
    out_ch.ready      = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    cycle_count  = 0;

    dest_corner = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_8000, 32'h0000_8000};
    src_corner  = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF};

    // Directed: field extremes and each divide special case
    queue_op(CMD_MULU, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    queue_op(CMD_MULU, 32'hFFFF_0000, 16'h1234, 1'b0);  // zero product
    queue_op(CMD_MULU, 32'h0000_8000, 16'h0002, 1'b0);
    queue_op(CMD_MULS, 32'h0000_8000, 16'h8000, 1'b0);  // most negative squared
    queue_op(CMD_MULS, 32'h0000_8000, 16'h7FFF, 1'b0);
    queue_op(CMD_MULS, 32'hABCD_FFFF, 16'hFFFF, 1'b0);  // -1 * -1
    queue_op(CMD_MULS, 32'h0000_0003, 16'hFFFE, 1'b0);
    queue_op(CMD_DIVU, 32'h1234_5678, 16'h0000, 1'b0);  // divide by zero
    queue_op(CMD_DIVS, 32'h8000_0000, 16'h0000, 1'b0);  // divide by zero
    queue_op(CMD_DIVU, 32'h0001_0000, 16'h0001, 1'b0);  // quotient overflow
    queue_op(CMD_DIVU, 32'hFFFE_FFFF, 16'hFFFF, 1'b0);  // largest in-range quotient
    queue_op(CMD_DIVU, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);  // just over
    queue_op(CMD_DIVU, 32'h0000_0005, 16'h0007, 1'b0);  // zero quotient
    queue_op(CMD_DIVS, 32'h8000_0000, 16'hFFFF, 1'b0);  // most negative by -1
    queue_op(CMD_DIVS, 32'hFFFF_8000, 16'h0001, 1'b0);  // quotient -32768
    queue_op(CMD_DIVS, 32'h0000_8000, 16'h0001, 1'b0);  // quotient +32768, overflow
    queue_op(CMD_DIVS, 32'h0000_7FFF, 16'h0001, 1'b0);  // quotient +32767
    queue_op(CMD_DIVS, 32'hFFFF_FFF9, 16'h0002, 1'b0);  // -7 / 2, negative remainder
    queue_op(CMD_DIVS, 32'h0000_0007, 16'hFFFE, 1'b0);  // 7 / -2
    queue_op(CMD_DIVS, 32'hFFFF_FFFF, 16'h8000, 1'b0);  // zero quotient, remainder -1
    queue_op(CMD_DIVS, 32'h4000_0000, 16'h8000, 1'b0);  // -32768 via negative divisor
    queue_op(CMD_DIVS, 32'h8000_0000, 16'h8000, 1'b0);  // +65536, overflow
    queue_op(CMD_DIVS, 32'h7FFF_FFFF, 16'h7FFF, 1'b0);

    // Random words; most divides are built to land in range or just past it
    for (int i = 0; i < RANDOM_OPS; i++) begin
      cmd  = wmd_cmd_t'($urandom_range(0, 3));
      dest = ($urandom_range(0, 7) == 0) ? dest_corner[$urandom_range(0, 7)] : $urandom;
      src  = ($urandom_range(0, 7) == 0) ? src_corner[$urandom_range(0, 4)]
                                         : WORD_W'($urandom_range(0, 16'hFFFF));
      if (cmd == CMD_DIVU && $urandom_range(0, 99) < 65) begin
        src = WORD_W'($urandom_range(1, 16'hFFFF));
        case ($urandom_range(0, 5))
          0:       quo = 32'h0000_FFFF;
          1:       quo = 32'h0001_0000;
          default: quo = $urandom_range(0, 16'hFFFF);
        endcase
        dest = quo * {16'h0, src} + ($urandom % {16'h0, src});
      end else if (cmd == CMD_DIVS && $urandom_range(0, 99) < 65) begin
        src  = WORD_W'($urandom_range(1, 16'hFFFF));
        dneg = $urandom_range(0, 1);
        qneg = dneg ^ src[WORD_W-1];
        smag = src[WORD_W-1] ? (32'h0001_0000 - {16'h0, src}) : {16'h0, src};
        qmax = qneg ? QUO_NEG_MAX : QUO_POS_MAX;
        case ($urandom_range(0, 5))
          0:       quo = qmax;
          1:       quo = qmax + 1;
          default: quo = $urandom_range(0, qmax);
        endcase
        dmag = quo * smag + ($urandom % smag);
        dest = dneg ? (32'h0 - dmag) : dmag;
      end
      // pause for a full drain at the start of the random part and midway
      queue_op(cmd, dest, src, (i == 0) || (i == RANDOM_OPS / 2));
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last word to go in and every result to come out
    while (muldiv_ops_q.size() != 0 || in_ch.valid || expected_outcomes_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    // a result still owed at the end counts as a failure
    if (mismatches == 0 && expected_outcomes_q.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/wmd_pkg.sv
hw/rtl/wmd_in_if.sv
hw/rtl/wmd_out_if.sv
hw/rtl/wmd_datapath.sv
hw/rtl/wmd_controller.sv
hw/rtl/word_multiply_divide_unit_top.sv
hw/rtl/wmd_checker.sv
dv/word_multiply_divide_unit_top_tb.sv
